// File: hw/rtl/lhw_pkg.sv
// Package for the link health watchdog: payload structs, register map,
// reset values and the state record shared by the step logic and the top level.
// No dependencies.
package lhw_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_BEFORE_PROBE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_RETRY        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAILS_BEFORE_RECOV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REBOOT_AFTER       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECONNECT_INTERVAL = 3'd4;

    localparam logic [1:0] KIND_CHECK       = 2'd0;
    localparam logic [1:0] KIND_TRAFFIC     = 2'd1;
    localparam logic [1:0] KIND_PROBE_REPLY = 2'd2;
    localparam logic [1:0] KIND_PROBE_END   = 2'd3;

    localparam logic REASON_NO_ASSOC  = 1'b0;
    localparam logic REASON_GW_UNREACH = 1'b1;

    localparam logic [7:0] FAIL_COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_ms;
        logic        link_connected;
        logic        ap_associated;
        logic        gateway_known;
    } t_lhw_in;

    typedef struct packed {
        logic        do_reconnect;
        logic        do_resync;
        logic        start_probe;
        logic        restart_radio;
        logic        recover_reason;
        logic        do_reboot;
        logic [31:0] recovery_total;
    } t_lhw_out;

    typedef struct packed {
        logic [31:0] idle_before_probe_ms;
        logic [31:0] probe_retry_ms;
        logic [7:0]  fails_before_recovery;
        logic [31:0] reboot_after_ms;
        logic [31:0] reconnect_interval_ms;
    } t_lhw_cfg;

    localparam t_lhw_cfg CFG_RESET = '{
        idle_before_probe_ms:  32'd120000,
        probe_retry_ms:        32'd60000,
        fails_before_recovery: 8'd2,
        reboot_after_ms:       32'd360000,
        reconnect_interval_ms: 32'd30000
    };

    typedef struct packed {
        logic [31:0] last_traffic_time;
        logic [31:0] bad_since_time;
        logic [31:0] last_recovery_time;
        logic [31:0] next_probe_time;
        logic [31:0] last_reconnect_time;
        logic [31:0] disconnect_time;
        logic [7:0]  probe_failures;
        logic        probe_active;
        logic        reply_seen;
        logic        probe_finished;
        logic [31:0] recovery_count;
    } t_lhw_state;

endpackage

// File: hw/rtl/link_health_watchdog.sv
// Top level of the link health watchdog: channel registers, watchdog state,
// configuration registers. Uses lhw_pkg and lhw_step.
//
//   channel   direction  handshake                    payload
//   in        input      i_in_valid  / o_in_ready     i_in_data   (t_lhw_in)
//   out       output     o_out_valid / i_out_ready    o_out_data  (t_lhw_out)
//   cfg       input      i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One event per cycle while results are taken; each event passes the input
// register, then the result register, set by the one-step update in lhw_step.
// Synchronous active-low reset clears state and loads register defaults; a
// reboot result does the same. A stalled result holds the input register,
// which then blocks new input until the result moves.
module link_health_watchdog (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  lhw_pkg::t_lhw_in                    i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output lhw_pkg::t_lhw_out                   o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lhw_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [31:0]                         i_cfg_data
);

    lhw_pkg::t_lhw_in    r_in;
    logic                r_in_vld;
    lhw_pkg::t_lhw_out   r_out;
    logic                r_out_vld;
    lhw_pkg::t_lhw_state r_state;
    lhw_pkg::t_lhw_cfg   r_cfg;

    lhw_pkg::t_lhw_state n_state;
    lhw_pkg::t_lhw_out   n_out;
    lhw_pkg::t_lhw_cfg   n_cfg;
    logic                w_reboot;
    logic                w_adv;

    assign w_adv       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || w_adv;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    lhw_step u_step (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_out),
        .o_reboot (w_reboot)
    );

    always_comb begin
        n_cfg = r_cfg;
        if (w_adv && w_reboot) begin
            n_cfg = lhw_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lhw_pkg::CFG_IDLE_BEFORE_PROBE:  n_cfg.idle_before_probe_ms  = i_cfg_data;
                lhw_pkg::CFG_PROBE_RETRY:        n_cfg.probe_retry_ms        = i_cfg_data;
                lhw_pkg::CFG_FAILS_BEFORE_RECOV: n_cfg.fails_before_recovery = i_cfg_data[7:0];
                lhw_pkg::CFG_REBOOT_AFTER:       n_cfg.reboot_after_ms       = i_cfg_data;
                lhw_pkg::CFG_RECONNECT_INTERVAL: n_cfg.reconnect_interval_ms = i_cfg_data;
                default:                         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
            r_cfg     <= lhw_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_reboot_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.do_reboot |->
            o_out_data.recovery_total == 32'd0 && !o_out_data.restart_radio
            && !o_out_data.start_probe && !o_out_data.do_resync)
        else $error("reboot result carries other flags");

    a_reason_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.restart_radio |-> !o_out_data.recover_reason)
        else $error("recover reason without restart");

    a_probe_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && n_out.start_probe |=> r_state.probe_active)
        else $error("probe start did not mark probe active");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_out_valid)
        else $error("advanced event produced no result");

    a_restart_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && n_out.restart_radio |->
            n_state.recovery_count == r_state.recovery_count + 32'd1)
        else $error("restart without recovery count step");
`endif

endmodule

// File: hw/rtl/lhw_step.sv
// Next-state and result logic for one watchdog event.
// Purely combinational; uses lhw_pkg for payload, register and state types.
module lhw_step (
    input  lhw_pkg::t_lhw_in    i_item,
    input  lhw_pkg::t_lhw_state i_state,
    input  lhw_pkg::t_lhw_cfg   i_cfg,
    output lhw_pkg::t_lhw_state o_state,
    output lhw_pkg::t_lhw_out   o_result,
    output logic                o_reboot
);

    logic [31:0] t;
    logic [31:0] probe_next;
    logic        cooling;
    logic        resync;
    logic [31:0] bad_cur;
    logic        bad_too_long;
    logic [7:0]  fails_inc;
    logic        recover_req;
    logic        why;
    logic [31:0] idle_age;
    logic [31:0] probe_lag;

    always_comb begin
        o_state     = i_state;
        o_result    = '0;
        o_reboot    = 1'b0;
        recover_req = 1'b0;
        why         = lhw_pkg::REASON_NO_ASSOC;
        t           = i_item.now_ms;
        probe_next  = t + i_cfg.probe_retry_ms;
        cooling     = (t - i_state.last_recovery_time) < i_cfg.probe_retry_ms;
        resync      = (i_state.disconnect_time != 32'd0);
        bad_cur     = resync ? 32'd0 : i_state.bad_since_time;
        bad_too_long = (bad_cur != 32'd0) && ((t - bad_cur) > i_cfg.reboot_after_ms);
        fails_inc   = resync ? 8'd1 :
                      ((i_state.probe_failures < lhw_pkg::FAIL_COUNT_MAX) ?
                       i_state.probe_failures + 8'd1 : i_state.probe_failures);
        idle_age    = 32'd0;
        probe_lag   = 32'd0;

        case (i_item.kind)
            lhw_pkg::KIND_TRAFFIC: begin
                o_state.last_traffic_time = t;
                o_state.bad_since_time    = 32'd0;
                o_state.probe_failures    = 8'd0;
            end
            lhw_pkg::KIND_PROBE_REPLY: begin
                o_state.reply_seen = 1'b1;
            end
            lhw_pkg::KIND_PROBE_END: begin
                o_state.probe_finished = 1'b1;
            end
            lhw_pkg::KIND_CHECK: begin
                if (!i_item.link_connected) begin
                    if (i_state.disconnect_time == 32'd0) begin
                        o_state.disconnect_time = t;
                    end
                    if ((t - i_state.last_reconnect_time) > i_cfg.reconnect_interval_ms) begin
                        o_result.do_reconnect       = 1'b1;
                        o_state.last_reconnect_time = t;
                    end
                end else begin
                    if (resync) begin
                        o_state.disconnect_time   = 32'd0;
                        o_result.do_resync        = 1'b1;
                        o_state.last_traffic_time = t;
                        o_state.bad_since_time    = 32'd0;
                        o_state.probe_failures    = 8'd0;
                    end
                    if (o_state.last_traffic_time == 32'd0) begin
                        o_state.last_traffic_time = t;
                    end
                    idle_age  = t - o_state.last_traffic_time;
                    probe_lag = t - i_state.next_probe_time;
                    if (!i_item.ap_associated) begin
                        if (!cooling) begin
                            recover_req = 1'b1;
                            why         = lhw_pkg::REASON_NO_ASSOC;
                        end
                    end else if (i_state.probe_active) begin
                        if (i_state.probe_finished) begin
                            o_state.probe_active    = 1'b0;
                            o_state.next_probe_time = probe_next;
                            if (i_state.reply_seen) begin
                                o_state.last_traffic_time = t;
                                o_state.bad_since_time    = 32'd0;
                                o_state.probe_failures    = 8'd0;
                            end else begin
                                o_state.probe_failures = fails_inc;
                                if (fails_inc >= i_cfg.fails_before_recovery && !cooling) begin
                                    recover_req = 1'b1;
                                    why         = lhw_pkg::REASON_GW_UNREACH;
                                end
                            end
                        end
                    end else if (idle_age >= i_cfg.idle_before_probe_ms && !probe_lag[31]) begin
                        o_state.next_probe_time = probe_next;
                        if (i_item.gateway_known) begin
                            o_state.probe_active   = 1'b1;
                            o_state.reply_seen     = 1'b0;
                            o_state.probe_finished = 1'b0;
                            o_result.start_probe   = 1'b1;
                        end
                    end
                    if (recover_req) begin
                        if (bad_too_long) begin
                            o_reboot = 1'b1;
                        end else begin
                            if (bad_cur == 32'd0) begin
                                o_state.bad_since_time = t;
                            end
                            o_state.probe_active       = 1'b0;
                            o_state.recovery_count     = i_state.recovery_count + 32'd1;
                            o_state.probe_failures     = 8'd0;
                            o_state.last_recovery_time = t;
                            o_state.next_probe_time    = probe_next;
                            o_state.last_traffic_time  = t;
                            o_state.disconnect_time    = t;
                            o_result.restart_radio     = 1'b1;
                            o_result.recover_reason    = why;
                        end
                    end
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase

        if (o_reboot) begin
            o_state            = '0;
            o_result           = '0;
            o_result.do_reboot = 1'b1;
        end
        o_result.recovery_total = o_state.recovery_count;
    end

endmodule

// File: tb/link_health_watchdog_checker.sv
// Checker for the link health watchdog: follows the in, out and cfg channels,
// keeps its own copy of the watchdog state and registers, and compares every
// result transfer with the expected one. Depends on lhw_pkg.
module link_health_watchdog_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  lhw_pkg::t_lhw_in                i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  lhw_pkg::t_lhw_out               i_out_data,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [lhw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                     i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    lhw_pkg::t_lhw_cfg regs;
    logic [31:0] seen_traffic_ms;
    logic [31:0] bad_since_ms;
    logic [31:0] recovered_ms;
    logic [31:0] probe_due_ms;
    logic [31:0] reconnect_ms;
    logic [31:0] down_since_ms;
    logic [7:0]  failed_probes;
    logic        probing;
    logic        got_reply;
    logic        probe_done;
    logic [31:0] recoveries;

    lhw_pkg::t_lhw_out expected_results[$];
    int          mismatch_cnt = 0;
    int          waiting_cnt = 0;

    assign o_fail_count = mismatch_cnt;
    assign o_pending    = waiting_cnt;

    function automatic void clear_watchdog();
        seen_traffic_ms = '0;
        bad_since_ms    = '0;
        recovered_ms    = '0;
        probe_due_ms    = '0;
        reconnect_ms    = '0;
        down_since_ms   = '0;
        failed_probes   = '0;
        probing         = 1'b0;
        got_reply       = 1'b0;
        probe_done      = 1'b0;
        recoveries      = '0;
    endfunction

    function automatic void note_alive(logic [31:0] t);
        seen_traffic_ms = t;
        bad_since_ms    = '0;
        failed_probes   = '0;
    endfunction

    // Returns 1 when the link has been bad too long and a reboot is due.
    function automatic logic try_radio_restart(input logic [31:0] t, input logic why,
                                               inout lhw_pkg::t_lhw_out r);
        logic [31:0] bad_for;
        if (bad_since_ms == '0) bad_since_ms = t;
        bad_for = t - bad_since_ms;
        if (bad_for > regs.reboot_after_ms) return 1'b1;
        probing          = 1'b0;
        recoveries       = recoveries + 32'd1;
        failed_probes    = '0;
        recovered_ms     = t;
        probe_due_ms     = t + regs.probe_retry_ms;
        seen_traffic_ms  = t;
        down_since_ms    = t;
        r.restart_radio  = 1'b1;
        r.recover_reason = why;
        return 1'b0;
    endfunction

    function automatic lhw_pkg::t_lhw_out advance_watchdog(lhw_pkg::t_lhw_in ev);
        lhw_pkg::t_lhw_out r;
        logic        reboot;
        logic        cooling;
        logic [31:0] t;
        logic [31:0] gap;
        r      = '0;
        reboot = 1'b0;
        t      = ev.now_ms;
        case (ev.kind)
            lhw_pkg::KIND_TRAFFIC:     note_alive(t);
            lhw_pkg::KIND_PROBE_REPLY: got_reply = 1'b1;
            lhw_pkg::KIND_PROBE_END:   probe_done = 1'b1;
            lhw_pkg::KIND_CHECK: begin
                if (!ev.link_connected) begin
                    if (down_since_ms == '0) down_since_ms = t;
                    gap = t - reconnect_ms;
                    if (gap > regs.reconnect_interval_ms) begin
                        r.do_reconnect = 1'b1;
                        reconnect_ms   = t;
                    end
                end else begin
                    if (down_since_ms != '0) begin
                        down_since_ms = '0;
                        r.do_resync   = 1'b1;
                        note_alive(t);
                    end
                    if (seen_traffic_ms == '0) seen_traffic_ms = t;
                    gap     = t - recovered_ms;
                    cooling = gap < regs.probe_retry_ms;
                    if (!ev.ap_associated) begin
                        if (!cooling)
                            reboot = try_radio_restart(t, lhw_pkg::REASON_NO_ASSOC, r);
                    end else if (probing) begin
                        if (probe_done) begin
                            probing      = 1'b0;
                            probe_due_ms = t + regs.probe_retry_ms;
                            if (got_reply) begin
                                note_alive(t);
                            end else begin
                                if (failed_probes != lhw_pkg::FAIL_COUNT_MAX)
                                    failed_probes = failed_probes + 8'd1;
                                if (failed_probes >= regs.fails_before_recovery && !cooling)
                                    reboot = try_radio_restart(t, lhw_pkg::REASON_GW_UNREACH,
                                                               r);
                            end
                        end
                    end else begin
                        gap = t - seen_traffic_ms;
                        if (gap >= regs.idle_before_probe_ms) begin
                            gap = t - probe_due_ms;
                            if (!gap[31]) begin
                                probe_due_ms = t + regs.probe_retry_ms;
                                if (ev.gateway_known) begin
                                    probing       = 1'b1;
                                    got_reply     = 1'b0;
                                    probe_done    = 1'b0;
                                    r.start_probe = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        if (reboot) begin
            clear_watchdog();
            regs        = lhw_pkg::CFG_RESET;
            r           = '0;
            r.do_reboot = 1'b1;
        end
        r.recovery_total = recoveries;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_cnt < 40) $display("%0t ns: %s", $time, msg);
        mismatch_cnt++;
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin
        lhw_pkg::t_lhw_out want;
        if (!i_rst_n) begin
            clear_watchdog();
            regs = lhw_pkg::CFG_RESET;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    lhw_pkg::CFG_IDLE_BEFORE_PROBE:
                        regs.idle_before_probe_ms  = i_cfg_data;
                    lhw_pkg::CFG_PROBE_RETRY:
                        regs.probe_retry_ms        = i_cfg_data;
                    lhw_pkg::CFG_FAILS_BEFORE_RECOV:
                        regs.fails_before_recovery = i_cfg_data[7:0];
                    lhw_pkg::CFG_REBOOT_AFTER:
                        regs.reboot_after_ms       = i_cfg_data;
                    lhw_pkg::CFG_RECONNECT_INTERVAL:
                        regs.reconnect_interval_ms = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    compare_field("do_reconnect", 32'(i_out_data.do_reconnect),
                                  32'(want.do_reconnect));
                    compare_field("do_resync", 32'(i_out_data.do_resync),
                                  32'(want.do_resync));
                    compare_field("start_probe", 32'(i_out_data.start_probe),
                                  32'(want.start_probe));
                    compare_field("restart_radio", 32'(i_out_data.restart_radio),
                                  32'(want.restart_radio));
                    compare_field("recover_reason", 32'(i_out_data.recover_reason),
                                  32'(want.recover_reason));
                    compare_field("do_reboot", 32'(i_out_data.do_reboot),
                                  32'(want.do_reboot));
                    compare_field("recovery_total", i_out_data.recovery_total,
                                  want.recovery_total);
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(advance_watchdog(i_in_data));
        end
        waiting_cnt <= expected_results.size();
    end

endmodule

// File: tb/link_health_watchdog_tb.sv
// Top of the link health watchdog testbench: clock, reset, event and register
// stimulus with random idling on both sides, and the verdict.
// Depends on lhw_pkg, link_health_watchdog and link_health_watchdog_checker.
module link_health_watchdog_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned                   CYCLE_LIMIT     = 200000;
    localparam int unsigned                   HOLD_OFF_CYCLES = 300;
    localparam logic [lhw_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED  = 3'd7;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    lhw_pkg::t_lhw_in               in_data   = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    lhw_pkg::t_lhw_out              out_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [lhw_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [31:0]                    cfg_data  = '0;

    int                    fail_count;
    int                    pending;
    int unsigned           cycle_cnt     = 0;
    int unsigned           send_idle_pct = 23;
    int unsigned           recv_idle_pct = 51;
    bit                    hold_off_req  = 1'b0;
    logic [31:0]           clock_ms      = '0;
    logic                  link_up       = 1'b1;

    link_health_watchdog DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    link_health_watchdog_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    // Hold off for a long stretch on request, otherwise stall at random.
    initial forever begin
        @(posedge clk);
        if (hold_off_req) begin
            hold_off_req = 1'b0;
            out_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_event(lhw_pkg::t_lhw_in ev);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_fields(logic [1:0] kind, logic [31:0] t, logic link, logic assoc,
                               logic gw);
        lhw_pkg::t_lhw_in ev;
        ev.kind           = kind;
        ev.now_ms         = t;
        ev.link_connected = link;
        ev.ap_associated  = assoc;
        ev.gateway_known  = gw;
        send_event(ev);
    endtask

    task automatic write_reg(logic [lhw_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic wait_drain();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly a running clock with plausible status, the rest pure noise.
    function automatic lhw_pkg::t_lhw_in next_event(logic [31:0] step_max);
        lhw_pkg::t_lhw_in ev;
        int unsigned pick;
        ev.kind           = 2'($urandom_range(3));
        ev.now_ms         = $urandom;
        ev.link_connected = 1'($urandom_range(1));
        ev.ap_associated  = 1'($urandom_range(1));
        ev.gateway_known  = 1'($urandom_range(1));
        if ($urandom_range(7) != 0) begin
            if ($urandom_range(49) == 0)
                clock_ms = '0;
            else
                clock_ms = clock_ms + $urandom_range(step_max);
            ev.now_ms = clock_ms;
            pick = $urandom_range(99);
            if (pick < 50) begin
                if ($urandom_range(19) == 0) link_up = !link_up;
                ev.kind           = lhw_pkg::KIND_CHECK;
                ev.link_connected = link_up;
                ev.ap_associated  = ($urandom_range(99) < 85);
                ev.gateway_known  = ($urandom_range(99) < 85);
            end else if (pick < 60) begin
                ev.kind = lhw_pkg::KIND_TRAFFIC;
            end else if (pick < 78) begin
                ev.kind = lhw_pkg::KIND_PROBE_REPLY;
            end else begin
                ev.kind = lhw_pkg::KIND_PROBE_END;
            end
        end
        return ev;
    endfunction

    task automatic run_phase(lhw_pkg::t_lhw_cfg c, logic [31:0] start_ms,
                             logic [31:0] step_max, int n_items, int unsigned s_pct,
                             int unsigned r_pct, bit hold_off);
        wait_drain();
        write_reg(lhw_pkg::CFG_IDLE_BEFORE_PROBE, c.idle_before_probe_ms);
        write_reg(lhw_pkg::CFG_PROBE_RETRY, c.probe_retry_ms);
        write_reg(lhw_pkg::CFG_FAILS_BEFORE_RECOV, {24'd0, c.fails_before_recovery});
        write_reg(lhw_pkg::CFG_REBOOT_AFTER, c.reboot_after_ms);
        write_reg(lhw_pkg::CFG_RECONNECT_INTERVAL, c.reconnect_interval_ms);
        write_reg(CFG_IDX_UNUSED, $urandom);
        cfg_valid     <= 1'b0;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        clock_ms      = start_ms;
        if (hold_off) hold_off_req = 1'b1;
        repeat (n_items) send_event(next_event(step_max));
        in_valid <= 1'b0;
    endtask

    initial begin
        lhw_pkg::t_lhw_cfg c;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_fields(lhw_pkg::KIND_CHECK,       32'd0,      1'b1, 1'b1, 1'b1);
        send_fields(lhw_pkg::KIND_PROBE_REPLY, 32'd5,      1'b0, 1'b0, 1'b0);
        send_fields(lhw_pkg::KIND_PROBE_END,   32'd6,      1'b1, 1'b1, 1'b1);
        send_fields(lhw_pkg::KIND_CHECK,       32'd100,    1'b0, 1'b1, 1'b1);
        send_fields(lhw_pkg::KIND_CHECK,       32'd40000,  1'b0, 1'b0, 1'b0);
        send_fields(lhw_pkg::KIND_CHECK,       32'd41000,  1'b1, 1'b1, 1'b1);
        send_fields(lhw_pkg::KIND_CHECK,       32'd50000,  1'b1, 1'b0, 1'b1);
        send_fields(lhw_pkg::KIND_CHECK,       32'd70000,  1'b1, 1'b0, 1'b1);
        send_fields(lhw_pkg::KIND_TRAFFIC,     32'd71000,  1'b1, 1'b1, 1'b1);
        send_fields(lhw_pkg::KIND_CHECK,       32'd200000, 1'b1, 1'b1, 1'b0);
        send_fields(lhw_pkg::KIND_CHECK,       32'd320000, 1'b1, 1'b1, 1'b0);
        send_fields(lhw_pkg::KIND_CHECK,       32'd380000, 1'b1, 1'b1, 1'b1);
        send_fields(lhw_pkg::KIND_PROBE_REPLY, 32'd380010, 1'b1, 1'b0, 1'b1);
        send_fields(lhw_pkg::KIND_PROBE_END,   32'd380020, 1'b0, 1'b1, 1'b0);
        send_fields(lhw_pkg::KIND_CHECK,       32'd380030, 1'b1, 1'b1, 1'b1);
        send_fields(lhw_pkg::KIND_CHECK,       32'd500030, 1'b1, 1'b1, 1'b1);
        send_fields(lhw_pkg::KIND_PROBE_END,   32'd500040, 1'b0, 1'b0, 1'b0);
        send_fields(lhw_pkg::KIND_CHECK,       32'd500050, 1'b1, 1'b1, 1'b1);
        send_fields(lhw_pkg::KIND_CHECK,       32'd620050, 1'b1, 1'b1, 1'b1);
        send_fields(lhw_pkg::KIND_PROBE_END,   32'd620060, 1'b1, 1'b1, 1'b1);
        send_fields(lhw_pkg::KIND_CHECK,       32'd620070, 1'b1, 1'b1, 1'b1);
        send_fields(lhw_pkg::KIND_CHECK,       32'hFFFFFFFF, 1'b0, 1'b1, 1'b1);
        send_fields(lhw_pkg::KIND_TRAFFIC,     32'd0,      1'b1, 1'b1, 1'b1);
        send_fields(lhw_pkg::KIND_CHECK,       32'hFFFFFFFF, 1'b1, 1'b0, 1'b0);
        in_valid <= 1'b0;

        c = '{idle_before_probe_ms: 32'd40, probe_retry_ms: 32'd25,
              fails_before_recovery: 8'd2, reboot_after_ms: 32'd100,
              reconnect_interval_ms: 32'd15};
        run_phase(c, 32'd1000, 32'd30, 500, 23, 51, 1'b0);

        c = '{idle_before_probe_ms: 32'd0, probe_retry_ms: 32'd0,
              fails_before_recovery: 8'd0, reboot_after_ms: 32'd0,
              reconnect_interval_ms: 32'd0};
        run_phase(c, 32'hFFFFFF00, 32'd5, 400, 51, 23, 1'b0);

        c = '{idle_before_probe_ms: 32'hFFFFFFFF, probe_retry_ms: 32'hFFFFFFFF,
              fails_before_recovery: 8'hFF, reboot_after_ms: 32'hFFFFFFFF,
              reconnect_interval_ms: 32'hFFFFFFFF};
        run_phase(c, 32'd1, 32'hFFFFFFFF, 300, 0, 0, 1'b0);

        run_phase(lhw_pkg::CFG_RESET, 32'd5000, 32'd50000, 550, 0, 0, 1'b1);

        wait_drain();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/lhw_pkg.sv
hw/rtl/lhw_step.sv
hw/rtl/link_health_watchdog.sv
tb/link_health_watchdog_checker.sv
tb/link_health_watchdog_tb.sv
